/* hw/rtl/adam_sgd_parameter_update_unit_macros.svh */
// Assertion macros for the Adam/SGD parameter update unit
`ifndef ADAM_SGD_PARAMETER_UPDATE_UNIT_MACROS_SVH
`define ADAM_SGD_PARAMETER_UPDATE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASGD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASGD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/asgd_pkg.sv */
// Shared constants and types of the Adam/SGD parameter update unit
package asgd_pkg;

    localparam int WEIGHT_COUNT = 4096;
    localparam int ADDR_W       = $clog2(WEIGHT_COUNT);
    localparam int IDX_W        = 12;
    localparam int M_W          = 32;
    localparam int V_W          = 48;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int DIV_N_W      = 128;
    localparam int DIV_D_W      = 64;
    localparam int DIV_CNT_W    = $clog2(DIV_N_W);

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd4;

    localparam logic        RST_MODE  = 1'b1;
    localparam logic [23:0] RST_LR    = 24'd16777;
    localparam logic [15:0] RST_BETA1 = 16'd58982;
    localparam logic [15:0] RST_BETA2 = 16'd65470;
    localparam logic [31:0] RST_EPS   = 32'd43;
    localparam logic [31:0] POW_ONE   = 32'hFFFF_FFFF;
    localparam logic [16:0] ONE_Q16   = 17'h1_0000;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [33:0] STEP_CAP  = 34'h2_0000_0000;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_POW1, S_POW2, S_M1, S_M2, S_M3, S_V1, S_V2, S_V3, S_V4,
        S_MH_WT, S_VH_WT, S_SQI, S_SQ, S_D, S_L1, S_L2, S_L3, S_Q_WT, S_PL, S_AP, S_DONE
    } t_state;

endpackage

/* hw/rtl/asgd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read
module asgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/asgd_div.sv */
// Restoring divider, one quotient bit per cycle, low 64 quotient bits kept
module asgd_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [asgd_pkg::DIV_N_W-1:0] i_num,
    input  logic [asgd_pkg::DIV_D_W-1:0] i_den,
    output logic                         o_done,
    output logic [asgd_pkg::DIV_D_W-1:0] o_quot
);
    logic                           r_busy;
    logic                           r_done;
    logic [asgd_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [asgd_pkg::DIV_N_W-1:0]   r_num;
    logic [asgd_pkg::DIV_D_W-1:0]   r_den;
    logic [asgd_pkg::DIV_D_W-1:0]   r_rem;
    logic [asgd_pkg::DIV_D_W-1:0]   r_quot;
    logic [asgd_pkg::DIV_D_W:0]     rem_s;
    logic                           ge;

    assign rem_s  = {r_rem, r_num[asgd_pkg::DIV_N_W-1]};
    assign ge     = rem_s >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= asgd_pkg::DIV_CNT_W'(asgd_pkg::DIV_N_W - 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_num  <= {r_num[asgd_pkg::DIV_N_W-2:0], 1'b0};
            r_rem  <= ge ? asgd_pkg::DIV_D_W'(rem_s - {1'b0, r_den})
                         : rem_s[asgd_pkg::DIV_D_W-1:0];
            r_quot <= {r_quot[asgd_pkg::DIV_D_W-2:0], ge};
        end else if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end
    end
endmodule

/* hw/rtl/adam_sgd_parameter_update_unit.sv */
// Top level of the Adam/SGD parameter update unit
//
//  channel | handshake                       | payload
//  in      | i_in_valid / o_in_stall         | index, weight, gradient, step_start
//  out     | o_out_valid / i_out_stall       | weight_out, saturated
//  cfg     | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
//
// One word at a time. Adaptive mode: a step open adds the two beta-power updates; each word
// takes up to three passes of the shared bit-serial divider and a bit-serial square root.
// Plain mode: one multiply, apply, output load per word.
// After reset a clearing pass zeroes all 4096 entries of both moment memories; the input
// stalls meanwhile. A finished word waits in the output register while the next
// input word is taken.
`include "adam_sgd_parameter_update_unit_macros.svh"
module adam_sgd_parameter_update_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [asgd_pkg::IDX_W-1:0]      i_weight_index,
    input  logic signed [31:0]              i_weight_in,
    input  logic signed [31:0]              i_gradient_in,
    input  logic                            i_step_start,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [31:0]              o_weight_out,
    output logic                            o_saturated,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [asgd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [asgd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    asgd_pkg::t_state r_state, n_state;
    logic [asgd_pkg::ADDR_W-1:0] r_ccnt, n_ccnt;
    logic [31:0] r_b1p, n_b1p, r_b2p, n_b2p;
    logic        r_mode;
    logic [23:0] r_lr;
    logic [15:0] r_beta1, r_beta2;
    logic [31:0] r_eps;
    logic        r_ov, n_ov;

    logic [asgd_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic signed [31:0] r_w, n_w, r_g, n_g, r_m, n_m;
    logic [31:0] r_ag, n_ag;
    logic        r_neg, n_neg, r_sat, n_sat;
    logic signed [48:0] r_ma, n_ma, r_mb, n_mb;
    logic [46:0] r_g2, n_g2;
    logic [63:0] r_va, n_va, r_vb, n_vb;
    logic [47:0] r_v, n_v;
    logic [63:0] r_mhat, n_mhat, r_vhat, n_vhat, r_q, n_q;
    logic [63:0] r_sx, n_sx, r_sres, n_sres, r_sbit, n_sbit;
    logic [4:0]  r_scnt, n_scnt;
    logic [48:0] r_d, n_d;
    logic [55:0] r_la, n_la, r_lb, n_lb;
    logic signed [31:0] r_res, n_res, r_wout, n_wout;
    logic        r_osat, n_osat;

    logic        in_acc;
    logic        mem_we;
    logic [asgd_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [asgd_pkg::M_W-1:0] m_wdata, m_rdata;
    logic [asgd_pkg::V_W-1:0] v_wdata, v_rdata;
    logic        div_start, div_done;
    logic [asgd_pkg::DIV_N_W-1:0] div_num;
    logic [asgd_pkg::DIV_D_W-1:0] div_den, div_quot;

    logic [16:0] omb1, omb2;
    logic [32:0] c1, c2;
    logic signed [49:0] m_sum;
    logic [64:0] v_sum;
    logic [47:0] v_new;
    logic [63:0] sq_t;
    logic [87:0] l_prod;
    logic [asgd_pkg::DIV_N_W-1:0] q_num;
    logic [48:0] d_raw;
    logic [33:0] mag34;
    logic signed [35:0] ap_sum;

    assign in_acc      = i_in_valid && (r_state == asgd_pkg::S_IDLE);
    assign o_in_stall  = (r_state != asgd_pkg::S_IDLE);
    assign o_out_valid = r_ov;
    assign o_weight_out = r_wout;
    assign o_saturated = r_osat;
    assign o_cfg_ready = 1'b1;
    assign mem_raddr   = (r_state == asgd_pkg::S_IDLE) ? i_weight_index[asgd_pkg::ADDR_W-1:0]
                                                       : r_idx;

    assign omb1   = asgd_pkg::ONE_Q16 - {1'b0, r_beta1};
    assign omb2   = asgd_pkg::ONE_Q16 - {1'b0, r_beta2};
    assign c1     = asgd_pkg::ONE_Q32 - {1'b0, r_b1p};
    assign c2     = asgd_pkg::ONE_Q32 - {1'b0, r_b2p};
    assign m_sum  = 50'(r_ma) + 50'(r_mb);
    assign v_sum  = 65'(r_va) + 65'(r_vb);
    assign v_new  = 48'(v_sum >> 16);
    assign sq_t   = r_sres + r_sbit;
    assign l_prod = 88'(r_la) + {r_lb, 32'b0};
    assign q_num  = {32'b0, l_prod, 8'b0};
    assign d_raw  = {1'b0, r_sres[31:0], 16'b0} + {17'b0, r_eps};
    assign mag34  = (r_q > 64'(asgd_pkg::STEP_CAP)) ? asgd_pkg::STEP_CAP : r_q[33:0];
    assign ap_sum = r_neg ? 36'(r_w) + signed'({2'b0, mag34})
                          : 36'(r_w) - signed'({2'b0, mag34});

    asgd_ram #(.WIDTH(asgd_pkg::M_W), .DEPTH(asgd_pkg::WEIGHT_COUNT)) u_m_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(m_wdata),
        .i_raddr(mem_raddr), .o_rdata(m_rdata)
    );

    asgd_ram #(.WIDTH(asgd_pkg::V_W), .DEPTH(asgd_pkg::WEIGHT_COUNT)) u_v_ram (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(v_wdata),
        .i_raddr(mem_raddr), .o_rdata(v_rdata)
    );

    asgd_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_quot(div_quot)
    );

    always_comb begin
        n_state = r_state;
        n_ccnt  = r_ccnt;
        n_b1p   = r_b1p;
        n_b2p   = r_b2p;
        n_ov    = r_ov;
        n_idx   = r_idx;
        n_w     = r_w;
        n_g     = r_g;
        n_ag    = r_ag;
        n_m     = r_m;
        n_neg   = r_neg;
        n_sat   = r_sat;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_g2    = r_g2;
        n_va    = r_va;
        n_vb    = r_vb;
        n_v     = r_v;
        n_mhat  = r_mhat;
        n_vhat  = r_vhat;
        n_q     = r_q;
        n_sx    = r_sx;
        n_sres  = r_sres;
        n_sbit  = r_sbit;
        n_scnt  = r_scnt;
        n_d     = r_d;
        n_la    = r_la;
        n_lb    = r_lb;
        n_res   = r_res;
        n_wout  = r_wout;
        n_osat  = r_osat;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        m_wdata   = r_m;
        v_wdata   = v_new;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;

        // drop the output word once taken
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            asgd_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ccnt;
                m_wdata   = '0;
                v_wdata   = '0;
                n_ccnt    = r_ccnt + 1'b1;
                if (r_ccnt == asgd_pkg::ADDR_W'(asgd_pkg::WEIGHT_COUNT - 1)) begin
                    n_state = asgd_pkg::S_IDLE;
                end
            end
            asgd_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_idx   = i_weight_index[asgd_pkg::ADDR_W-1:0];
                    n_w     = i_weight_in;
                    n_g     = i_gradient_in;
                    n_ag    = i_gradient_in[31] ? 32'(32'd0 - $unsigned(i_gradient_in))
                                                : $unsigned(i_gradient_in);
                    n_neg   = i_gradient_in[31];
                    n_sat   = 1'b0;
                    if (!r_mode) begin
                        n_state = asgd_pkg::S_PL;
                    end else if (i_step_start) begin
                        n_state = asgd_pkg::S_POW1;
                    end else begin
                        n_state = asgd_pkg::S_M1;
                    end
                end
            end
            asgd_pkg::S_POW1: begin
                n_b1p   = 32'((48'(r_b1p) * 48'(r_beta1)) >> 16);
                n_state = asgd_pkg::S_POW2;
            end
            asgd_pkg::S_POW2: begin
                n_b2p   = 32'((48'(r_b2p) * 48'(r_beta2)) >> 16);
                n_state = asgd_pkg::S_M1;
            end
            asgd_pkg::S_M1: begin
                n_ma    = 49'(signed'({1'b0, r_beta1})) * 49'(signed'(m_rdata));
                n_state = asgd_pkg::S_M2;
            end
            asgd_pkg::S_M2: begin
                n_mb    = 49'(signed'({1'b0, omb1})) * 49'(r_g);
                n_state = asgd_pkg::S_M3;
            end
            asgd_pkg::S_M3: begin
                n_m     = 32'(m_sum >>> 16);
                n_neg   = m_sum[49];
                n_state = asgd_pkg::S_V1;
            end
            asgd_pkg::S_V1: begin
                n_g2    = 47'((64'(r_ag) * 64'(r_ag)) >> 16);
                n_state = asgd_pkg::S_V2;
            end
            asgd_pkg::S_V2: begin
                n_va    = 64'(r_beta2) * 64'(v_rdata);
                n_state = asgd_pkg::S_V3;
            end
            asgd_pkg::S_V3: begin
                n_vb    = 64'(omb2) * 64'(r_g2);
                n_state = asgd_pkg::S_V4;
            end
            asgd_pkg::S_V4: begin
                mem_we    = 1'b1;
                n_v       = v_new;
                div_start = 1'b1;
                div_num   = {64'b0, (r_m[31] ? 32'(32'd0 - $unsigned(r_m)) : $unsigned(r_m)),
                             32'b0};
                div_den   = 64'(c1);
                n_state   = asgd_pkg::S_MH_WT;
            end
            asgd_pkg::S_MH_WT: begin
                if (div_done) begin
                    n_mhat = div_quot;
                    if (33'(r_v[47:32]) >= c2) begin
                        n_vhat  = '1;
                        n_sat   = 1'b1;
                        n_state = asgd_pkg::S_SQI;
                    end else begin
                        div_start = 1'b1;
                        div_num   = {48'b0, r_v, 32'b0};
                        div_den   = 64'(c2);
                        n_state   = asgd_pkg::S_VH_WT;
                    end
                end
            end
            asgd_pkg::S_VH_WT: begin
                if (div_done) begin
                    n_vhat  = div_quot;
                    n_state = asgd_pkg::S_SQI;
                end
            end
            asgd_pkg::S_SQI: begin
                n_sx    = r_vhat;
                n_sres  = '0;
                n_sbit  = 64'h4000_0000_0000_0000;
                n_scnt  = 5'd31;
                n_state = asgd_pkg::S_SQ;
            end
            asgd_pkg::S_SQ: begin
                if (r_sx >= sq_t) begin
                    n_sx   = r_sx - sq_t;
                    n_sres = (r_sres >> 1) + r_sbit;
                end else begin
                    n_sres = r_sres >> 1;
                end
                n_sbit = r_sbit >> 2;
                n_scnt = r_scnt - 1'b1;
                if (r_scnt == '0) begin
                    n_state = asgd_pkg::S_D;
                end
            end
            asgd_pkg::S_D: begin
                n_d     = (d_raw == '0) ? 49'd1 : d_raw;
                n_state = asgd_pkg::S_L1;
            end
            asgd_pkg::S_L1: begin
                n_la    = 56'(r_lr) * 56'(r_mhat[31:0]);
                n_state = asgd_pkg::S_L2;
            end
            asgd_pkg::S_L2: begin
                n_lb    = 56'(r_lr) * 56'(r_mhat[63:32]);
                n_state = asgd_pkg::S_L3;
            end
            asgd_pkg::S_L3: begin
                if (q_num[127:64] >= 64'(r_d)) begin
                    n_q     = '1;
                    n_sat   = 1'b1;
                    n_state = asgd_pkg::S_AP;
                end else begin
                    div_start = 1'b1;
                    div_num   = q_num;
                    div_den   = 64'(r_d);
                    n_state   = asgd_pkg::S_Q_WT;
                end
            end
            asgd_pkg::S_Q_WT: begin
                if (div_done) begin
                    n_q     = div_quot;
                    n_state = asgd_pkg::S_AP;
                end
            end
            asgd_pkg::S_PL: begin
                n_q     = 64'((56'(r_lr) * 56'(r_ag)) >> 24);
                n_state = asgd_pkg::S_AP;
            end
            asgd_pkg::S_AP: begin
                if (ap_sum > 36'sh0_7FFF_FFFF) begin
                    n_res = 32'sh7FFF_FFFF;
                    n_sat = 1'b1;
                end else if (ap_sum < 36'shF_8000_0000) begin
                    n_res = 32'sh8000_0000;
                    n_sat = 1'b1;
                end else begin
                    n_res = 32'(ap_sum);
                end
                n_state = asgd_pkg::S_DONE;
            end
            asgd_pkg::S_DONE: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov    = 1'b1;
                    n_wout  = r_res;
                    n_osat  = r_sat;
                    n_state = asgd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = asgd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asgd_pkg::S_CLEAR;
            r_ccnt  <= '0;
            r_b1p   <= asgd_pkg::POW_ONE;
            r_b2p   <= asgd_pkg::POW_ONE;
            r_ov    <= 1'b0;
            r_mode  <= asgd_pkg::RST_MODE;
            r_lr    <= asgd_pkg::RST_LR;
            r_beta1 <= asgd_pkg::RST_BETA1;
            r_beta2 <= asgd_pkg::RST_BETA2;
            r_eps   <= asgd_pkg::RST_EPS;
        end else begin
            r_state <= n_state;
            r_ccnt  <= n_ccnt;
            r_b1p   <= n_b1p;
            r_b2p   <= n_b2p;
            r_ov    <= n_ov;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    asgd_pkg::CFG_MODE:  r_mode  <= i_cfg_data[0];
                    asgd_pkg::CFG_LR:    r_lr    <= i_cfg_data[23:0];
                    asgd_pkg::CFG_BETA1: r_beta1 <= i_cfg_data[15:0];
                    asgd_pkg::CFG_BETA2: r_beta2 <= i_cfg_data[15:0];
                    asgd_pkg::CFG_EPS:   r_eps   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_w     <= n_w;
        r_g     <= n_g;
        r_ag    <= n_ag;
        r_m     <= n_m;
        r_neg   <= n_neg;
        r_sat   <= n_sat;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_g2    <= n_g2;
        r_va    <= n_va;
        r_vb    <= n_vb;
        r_v     <= n_v;
        r_mhat  <= n_mhat;
        r_vhat  <= n_vhat;
        r_q     <= n_q;
        r_sx    <= n_sx;
        r_sres  <= n_sres;
        r_sbit  <= n_sbit;
        r_scnt  <= n_scnt;
        r_d     <= n_d;
        r_la    <= n_la;
        r_lb    <= n_lb;
        r_res   <= n_res;
        r_wout  <= n_wout;
        r_osat  <= n_osat;
    end

    `ASGD_ASSERT_IMPL(a_div_done_awaited, i_clk, i_rst_n, div_done, (r_state == asgd_pkg::S_MH_WT) || (r_state == asgd_pkg::S_VH_WT) || (r_state == asgd_pkg::S_Q_WT), "divider finished outside a wait state")
    `ASGD_ASSERT_IMPL(a_out_from_done, i_clk, i_rst_n, $rose(r_ov), $past(r_state == asgd_pkg::S_DONE), "output word loaded outside done state")
    `ASGD_ASSERT_IMPL(a_clear_quiet, i_clk, i_rst_n, r_state == asgd_pkg::S_CLEAR, !r_ov, "output word during clearing pass")
    `ASGD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall, "input not stalled after accepting a word")
endmodule
